>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the two-locus step block
// each macro assumes clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked at every clock edge out of reset
`define TLBD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TLBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tlbd_pkg.sv
// package for the two-locus birth-death step block
// widths, codes, sequencer types; no dependencies
package tlbd_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int DRAW_BITS    = 32;
    localparam int RATE_BITS    = 24;
    localparam int RECOMB_BITS  = 17;
    localparam int FRAC_BITS    = 16;
    localparam int NUM_EVENTS   = 8;
    localparam int EV_BITS      = 4;
    localparam int EVW          = $clog2(NUM_EVENTS);
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 24;

    // operand widths of the event weight arithmetic
    localparam int GRP_BITS   = COUNT_BITS + 1;
    localparam int SUM_BITS   = COUNT_BITS + 2;
    localparam int BSUM_BITS  = GRP_BITS + RATE_BITS + 1;
    localparam int PQ_BITS    = 2 * COUNT_BITS;
    localparam int RDL_BITS   = PQ_BITS + RECOMB_BITS;
    localparam int S2_BITS    = 2 * SUM_BITS;
    localparam int BASE_BITS  = COUNT_BITS + SUM_BITS;
    localparam int SHARE_BITS = BASE_BITS + FRAC_BITS + 1;
    localparam int ND_BITS    = COUNT_BITS + RATE_BITS;
    localparam int TOT_BITS   = BSUM_BITS + SHARE_BITS + 3;

    // limb arithmetic of the shared multiplier
    localparam int LIMB      = 32;
    localparam int ACC_LIMBS = (TOT_BITS + DRAW_BITS + LIMB - 1) / LIMB;
    localparam int ACC_W     = ACC_LIMBS * LIMB;
    localparam int LC_W      = $clog2(ACC_LIMBS + 1);
    localparam int LI_W      = $clog2(ACC_LIMBS);
    localparam int SH_W      = LI_W + 1;

    localparam int L_GRP   = (GRP_BITS + LIMB - 1) / LIMB;
    localparam int L_RATE  = (RATE_BITS + LIMB - 1) / LIMB;
    localparam int L_CNT   = (COUNT_BITS + LIMB - 1) / LIMB;
    localparam int L_PQ    = (PQ_BITS + LIMB - 1) / LIMB;
    localparam int L_RR    = (RECOMB_BITS + LIMB - 1) / LIMB;
    localparam int L_SUM   = (SUM_BITS + LIMB - 1) / LIMB;
    localparam int L_BSUM  = (BSUM_BITS + LIMB - 1) / LIMB;
    localparam int L_SHARE = (SHARE_BITS + LIMB - 1) / LIMB;
    localparam int L_ND    = (ND_BITS + LIMB - 1) / LIMB;
    localparam int L_S2    = (S2_BITS + LIMB - 1) / LIMB;
    localparam int L_TOT   = (TOT_BITS + LIMB - 1) / LIMB;
    localparam int L_DRAW  = (DRAW_BITS + LIMB - 1) / LIMB;

    typedef logic [ACC_W-1:0] wide_t;

    localparam logic [RECOMB_BITS-1:0] RATE_ONE   = RECOMB_BITS'(1) << FRAC_BITS;
    localparam logic [RATE_BITS-1:0]   RATE_RESET = RATE_BITS'(1) << FRAC_BITS;
    localparam logic [EV_BITS-1:0]     EV_NONE    = EV_BITS'(NUM_EVENTS);

    localparam logic OPC_STEP = 1'b0;
    localparam logic OPC_LOAD = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_BIRTH_BIG_A   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_BIRTH_SMALL_A = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_DEATH_BIG_A   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_DEATH_SMALL_A = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_RECOMB        = CFG_IDX_BITS'(4);

    typedef enum logic [1:0] {
        STS_OK,
        STS_EMPTY,
        STS_RATE_ZERO,
        STS_SATURATED
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_GO,
        FSM_WAIT,
        FSM_SCAN,
        FSM_UPDATE,
        FSM_OUT
    } fsm_t;

    typedef enum logic [3:0] {
        OP_BSUM_A,
        OP_BSUM_B,
        OP_P,
        OP_Q,
        OP_RDL,
        OP_S2,
        OP_BASE,
        OP_BIRTH,
        OP_ND,
        OP_DEATH,
        OP_THR
    } op_t;

    typedef struct packed {
        logic            start;
        logic [LC_W-1:0] na;
        logic [LC_W-1:0] nb;
    } mul_cmd_t;

endpackage

>>> hw/rtl/tlbd_if.sv
// valid/ready channel interfaces of the two-locus step block
// depends on tlbd_pkg for field widths
interface tlbd_in_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [tlbd_pkg::DRAW_BITS-1:0]  random_draw;
    logic [tlbd_pkg::COUNT_BITS-1:0] load_big_a_big_b;
    logic [tlbd_pkg::COUNT_BITS-1:0] load_big_a_small_b;
    logic [tlbd_pkg::COUNT_BITS-1:0] load_small_a_big_b;
    logic [tlbd_pkg::COUNT_BITS-1:0] load_small_a_small_b;

    modport source (
        output valid, opcode, random_draw, load_big_a_big_b, load_big_a_small_b,
               load_small_a_big_b, load_small_a_small_b,
        input  ready
    );
    modport sink (
        input  valid, opcode, random_draw, load_big_a_big_b, load_big_a_small_b,
               load_small_a_big_b, load_small_a_small_b,
        output ready
    );
endinterface

interface tlbd_out_if;
    logic                            valid;
    logic                            ready;
    logic [tlbd_pkg::COUNT_BITS-1:0] count_big_a_big_b;
    logic [tlbd_pkg::COUNT_BITS-1:0] count_big_a_small_b;
    logic [tlbd_pkg::COUNT_BITS-1:0] count_small_a_big_b;
    logic [tlbd_pkg::COUNT_BITS-1:0] count_small_a_small_b;
    logic [tlbd_pkg::EV_BITS-1:0]    event_res;
    logic [1:0]                      status;

    modport source (
        output valid, count_big_a_big_b, count_big_a_small_b, count_small_a_big_b,
               count_small_a_small_b, event_res, status,
        input  ready
    );
    modport sink (
        input  valid, count_big_a_big_b, count_big_a_small_b, count_small_a_big_b,
               count_small_a_small_b, event_res, status,
        output ready
    );
endinterface

>>> hw/rtl/tlbd_mul.sv
// shared multi-limb multiplier: one 32x32 product per cycle into a wide accumulator
// depends on tlbd_pkg; operands must hold steady while a product runs
`include "assert_macros.svh"

module tlbd_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  tlbd_pkg::mul_cmd_t cmd,
    input  tlbd_pkg::wide_t    a,
    input  tlbd_pkg::wide_t    b,
    input  tlbd_pkg::wide_t    init,
    output logic               done,
    output tlbd_pkg::wide_t    res
);

    logic                           run_reg;
    logic [tlbd_pkg::LI_W-1:0]      i_reg;
    logic [tlbd_pkg::LI_W-1:0]      j_reg;
    logic                           pv_reg;
    logic                           plast_reg;
    logic                           done_reg;
    logic [2*tlbd_pkg::LIMB-1:0]    prod_reg;
    logic [tlbd_pkg::SH_W-1:0]      sh_reg;
    tlbd_pkg::wide_t                acc_reg;

    logic [tlbd_pkg::LIMB-1:0]      a_limb;
    logic [tlbd_pkg::LIMB-1:0]      b_limb;
    logic                           j_last;
    logic                           i_last;
    tlbd_pkg::wide_t                addend;

    assign a_limb = a[int'(i_reg) * tlbd_pkg::LIMB +: tlbd_pkg::LIMB];
    assign b_limb = b[int'(j_reg) * tlbd_pkg::LIMB +: tlbd_pkg::LIMB];
    assign j_last = tlbd_pkg::LC_W'(j_reg) == cmd.nb - tlbd_pkg::LC_W'(1);
    assign i_last = tlbd_pkg::LC_W'(i_reg) == cmd.na - tlbd_pkg::LC_W'(1);
    assign addend = tlbd_pkg::wide_t'(prod_reg) << (int'(sh_reg) * tlbd_pkg::LIMB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= pv_reg && plast_reg;
            if (cmd.start)
            begin
                run_reg   <= 1'b1;
                i_reg     <= '0;
                j_reg     <= '0;
                pv_reg    <= 1'b0;
                plast_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                pv_reg    <= 1'b1;
                plast_reg <= i_last && j_last;
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                    if (i_last)
                    begin
                        run_reg <= 1'b0;
                    end
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            else
            begin
                pv_reg    <= 1'b0;
                plast_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_limb * b_limb;
        sh_reg   <= tlbd_pkg::SH_W'(i_reg) + tlbd_pkg::SH_W'(j_reg);
        if (cmd.start)
        begin
            acc_reg <= init;
        end
        else if (pv_reg && (sh_reg < tlbd_pkg::SH_W'(tlbd_pkg::ACC_LIMBS)))
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

    `TLBD_ASSERT_IMP(a_start_idle, cmd.start, !run_reg && !pv_reg && !done_reg, "mul started while busy")
    `TLBD_ASSERT_NXT(a_done_after_last, pv_reg && plast_reg, done_reg, "mul done missing")
    `TLBD_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "mul done longer than one cycle")

endmodule

>>> hw/rtl/two_locus_birth_death_step.sv
// two-locus birth-death step: four genotype counts, at most one event per step item
// load item or step on an empty population: result valid the cycle after the transfer,
//   next transfer taken from the cycle after the result transfer
// step item: 23 products on the shared 32x32 multiplier, 49 limb pairs in all, then a scan
//   over the 8 event weights that stops at the first hit; a zero total rate skips threshold and scan
// reset: counts zero, rates one, recombination zero; depends on tlbd_pkg, tlbd_if, tlbd_mul
`include "assert_macros.svh"

module two_locus_birth_death_step (
    input  logic                                clk,
    input  logic                                rst_n,
    tlbd_in_if.sink                             in_ch,
    tlbd_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [tlbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tlbd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // sequencer state
    tlbd_pkg::fsm_t                      state_reg;
    tlbd_pkg::fsm_t                      state_next;
    tlbd_pkg::op_t                       op_reg;
    tlbd_pkg::op_t                       op_next;
    logic [1:0]                          idx_reg;
    logic [1:0]                          idx_next;
    logic [tlbd_pkg::EVW-1:0]            k_reg;

    // genotype counts and configuration
    logic [tlbd_pkg::COUNT_BITS-1:0]     cnt_reg [4];
    logic [tlbd_pkg::RATE_BITS-1:0]      birth_big_reg;
    logic [tlbd_pkg::RATE_BITS-1:0]      birth_small_reg;
    logic [tlbd_pkg::RATE_BITS-1:0]      death_big_reg;
    logic [tlbd_pkg::RATE_BITS-1:0]      death_small_reg;
    logic [tlbd_pkg::RECOMB_BITS-1:0]    recomb_reg;

    // working registers of one step
    logic [tlbd_pkg::DRAW_BITS-1:0]      draw_reg;
    logic [tlbd_pkg::BSUM_BITS-1:0]      bsum_reg;
    logic [tlbd_pkg::PQ_BITS-1:0]        p_reg;
    logic [tlbd_pkg::PQ_BITS-1:0]        q_reg;
    logic [tlbd_pkg::RDL_BITS-1:0]       rdl_reg;
    logic [tlbd_pkg::S2_BITS-1:0]        s2_reg;
    logic [tlbd_pkg::SHARE_BITS-1:0]     share_reg;
    logic [tlbd_pkg::ND_BITS-1:0]        nd_reg;
    logic [tlbd_pkg::TOT_BITS-1:0]       wt_reg [tlbd_pkg::NUM_EVENTS];
    logic [tlbd_pkg::TOT_BITS-1:0]       total_reg;
    tlbd_pkg::wide_t                     thr_reg;
    logic [tlbd_pkg::TOT_BITS-1:0]       cum_reg;
    logic [tlbd_pkg::EV_BITS-1:0]        ev_reg;
    tlbd_pkg::status_t                   status_reg;

    // combinational helpers
    logic                                in_xfer;
    logic                                out_xfer;
    logic [tlbd_pkg::SUM_BITS-1:0]       s_sum;
    logic [tlbd_pkg::GRP_BITS-1:0]       grp_big;
    logic [tlbd_pkg::GRP_BITS-1:0]       grp_small;
    logic [tlbd_pkg::RECOMB_BITS-1:0]    rr_clamp;
    logic                                ld_neg;
    logic [tlbd_pkg::PQ_BITS-1:0]        ld_mag;
    logic [tlbd_pkg::COUNT_BITS-1:0]     cnt_sel;
    logic [tlbd_pkg::RATE_BITS-1:0]      drate_sel;
    logic                                share_minus;
    logic [tlbd_pkg::SHARE_BITS-1:0]     share_base;
    logic [tlbd_pkg::SHARE_BITS-1:0]     share_rdl;
    logic [tlbd_pkg::SHARE_BITS-1:0]     share_calc;
    tlbd_pkg::wide_t                     death_w;
    logic [tlbd_pkg::TOT_BITS-1:0]       wt_new;
    logic [tlbd_pkg::TOT_BITS-1:0]       total_sum;
    logic                                last_weight;
    logic [tlbd_pkg::TOT_BITS-1:0]       cum_sum;
    logic                                scan_hit;
    logic                                scan_end;
    logic                                sat;

    // shared multiplier hookup
    tlbd_pkg::mul_cmd_t                  mul_cmd;
    tlbd_pkg::wide_t                     mul_a;
    tlbd_pkg::wide_t                     mul_b;
    tlbd_pkg::wide_t                     mul_init;
    logic                                mul_done;
    tlbd_pkg::wide_t                     mul_res;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_ch.valid && out_ch.ready;

    // population size and allele group sizes
    assign grp_big   = tlbd_pkg::GRP_BITS'(cnt_reg[0]) + tlbd_pkg::GRP_BITS'(cnt_reg[1]);
    assign grp_small = tlbd_pkg::GRP_BITS'(cnt_reg[2]) + tlbd_pkg::GRP_BITS'(cnt_reg[3]);
    assign s_sum     = tlbd_pkg::SUM_BITS'(grp_big) + tlbd_pkg::SUM_BITS'(grp_small);

    // recombination above one acts as one
    assign rr_clamp = (recomb_reg > tlbd_pkg::RATE_ONE) ? tlbd_pkg::RATE_ONE : recomb_reg;

    // linkage disequilibrium as sign and magnitude
    assign ld_neg = p_reg < q_reg;
    assign ld_mag = ld_neg ? (q_reg - p_reg) : (p_reg - q_reg);

    assign cnt_sel   = cnt_reg[idx_reg];
    assign drate_sel = idx_reg[1] ? death_small_reg : death_big_reg;

    // birth share: n_i*s*2^16 minus or plus r*LD, floored at zero
    assign share_minus = ((idx_reg == 2'd0) || (idx_reg == 2'd3)) ? !ld_neg : ld_neg;
    assign share_base  = tlbd_pkg::SHARE_BITS'({mul_res[tlbd_pkg::BASE_BITS-1:0],
                                                {tlbd_pkg::FRAC_BITS{1'b0}}});
    assign share_rdl   = tlbd_pkg::SHARE_BITS'(rdl_reg);
    always_comb
    begin
        if (!share_minus)
        begin
            share_calc = share_base + share_rdl;
        end
        else if (share_base < share_rdl)
        begin
            share_calc = '0;
        end
        else
        begin
            share_calc = share_base - share_rdl;
        end
    end

    // new event weight and running total
    assign death_w     = mul_res << tlbd_pkg::FRAC_BITS;
    assign wt_new      = (op_reg == tlbd_pkg::OP_BIRTH) ? mul_res[tlbd_pkg::TOT_BITS-1:0]
                                                        : death_w[tlbd_pkg::TOT_BITS-1:0];
    assign total_sum   = total_reg + wt_new;
    assign last_weight = (op_reg == tlbd_pkg::OP_DEATH) && (idx_reg == 2'd3);

    // selection: cum*2^draw_bits > total*draw, same as cum > thr >> draw_bits
    assign cum_sum  = cum_reg + wt_reg[k_reg];
    assign scan_hit = tlbd_pkg::ACC_W'(cum_sum) >
                      tlbd_pkg::ACC_W'(thr_reg[tlbd_pkg::ACC_W-1:tlbd_pkg::DRAW_BITS]);
    assign scan_end = scan_hit || (k_reg == tlbd_pkg::EVW'(tlbd_pkg::NUM_EVENTS - 1));

    // a birth on a full count or a death on an empty one leaves counts alone
    assign sat = ev_reg[2] ? (cnt_sel == '0) : (cnt_sel == '1);

    // multiplier start and operand selection for each product of the step
    always_comb
    begin
        mul_cmd.start = state_reg == tlbd_pkg::FSM_GO;
        mul_a    = '0;
        mul_b    = '0;
        mul_init = '0;
        mul_cmd.na = tlbd_pkg::LC_W'(1);
        mul_cmd.nb = tlbd_pkg::LC_W'(1);
        case (op_reg)
            tlbd_pkg::OP_BSUM_A:
            begin
                mul_a = tlbd_pkg::wide_t'(grp_big);
                mul_b = tlbd_pkg::wide_t'(birth_big_reg);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_GRP);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_RATE);
            end
            tlbd_pkg::OP_BSUM_B:
            begin
                mul_a    = tlbd_pkg::wide_t'(grp_small);
                mul_b    = tlbd_pkg::wide_t'(birth_small_reg);
                mul_init = tlbd_pkg::wide_t'(bsum_reg);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_GRP);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_RATE);
            end
            tlbd_pkg::OP_P:
            begin
                mul_a = tlbd_pkg::wide_t'(cnt_reg[0]);
                mul_b = tlbd_pkg::wide_t'(cnt_reg[3]);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_CNT);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_CNT);
            end
            tlbd_pkg::OP_Q:
            begin
                mul_a = tlbd_pkg::wide_t'(cnt_reg[1]);
                mul_b = tlbd_pkg::wide_t'(cnt_reg[2]);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_CNT);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_CNT);
            end
            tlbd_pkg::OP_RDL:
            begin
                mul_a = tlbd_pkg::wide_t'(rr_clamp);
                mul_b = tlbd_pkg::wide_t'(ld_mag);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_RR);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_PQ);
            end
            tlbd_pkg::OP_S2:
            begin
                mul_a = tlbd_pkg::wide_t'(s_sum);
                mul_b = tlbd_pkg::wide_t'(s_sum);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_SUM);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_SUM);
            end
            tlbd_pkg::OP_BASE:
            begin
                mul_a = tlbd_pkg::wide_t'(cnt_sel);
                mul_b = tlbd_pkg::wide_t'(s_sum);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_CNT);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_SUM);
            end
            tlbd_pkg::OP_BIRTH:
            begin
                mul_a = tlbd_pkg::wide_t'(bsum_reg);
                mul_b = tlbd_pkg::wide_t'(share_reg);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_BSUM);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_SHARE);
            end
            tlbd_pkg::OP_ND:
            begin
                mul_a = tlbd_pkg::wide_t'(cnt_sel);
                mul_b = tlbd_pkg::wide_t'(drate_sel);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_CNT);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_RATE);
            end
            tlbd_pkg::OP_DEATH:
            begin
                mul_a = tlbd_pkg::wide_t'(nd_reg);
                mul_b = tlbd_pkg::wide_t'(s2_reg);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_ND);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_S2);
            end
            tlbd_pkg::OP_THR:
            begin
                mul_a = tlbd_pkg::wide_t'(total_reg);
                mul_b = tlbd_pkg::wide_t'(draw_reg);
                mul_cmd.na = tlbd_pkg::LC_W'(tlbd_pkg::L_TOT);
                mul_cmd.nb = tlbd_pkg::LC_W'(tlbd_pkg::L_DRAW);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // product order: rate sums, LD, s^2, then per genotype base, birth, n*d, death, then threshold
    always_comb
    begin
        op_next  = op_reg;
        idx_next = idx_reg;
        case (op_reg)
            tlbd_pkg::OP_BSUM_A: op_next = tlbd_pkg::OP_BSUM_B;
            tlbd_pkg::OP_BSUM_B: op_next = tlbd_pkg::OP_P;
            tlbd_pkg::OP_P:      op_next = tlbd_pkg::OP_Q;
            tlbd_pkg::OP_Q:      op_next = tlbd_pkg::OP_RDL;
            tlbd_pkg::OP_RDL:    op_next = tlbd_pkg::OP_S2;
            tlbd_pkg::OP_S2:     op_next = tlbd_pkg::OP_BASE;
            tlbd_pkg::OP_BASE:   op_next = tlbd_pkg::OP_BIRTH;
            tlbd_pkg::OP_BIRTH:  op_next = tlbd_pkg::OP_ND;
            tlbd_pkg::OP_ND:     op_next = tlbd_pkg::OP_DEATH;
            tlbd_pkg::OP_DEATH:
            begin
                if (idx_reg == 2'd3)
                begin
                    op_next = tlbd_pkg::OP_THR;
                end
                else
                begin
                    op_next  = tlbd_pkg::OP_BASE;
                    idx_next = idx_reg + 2'd1;
                end
            end
            default: op_next = op_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlbd_pkg::FSM_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((in_ch.opcode == tlbd_pkg::OPC_LOAD) || (s_sum == '0))
                    begin
                        state_next = tlbd_pkg::FSM_OUT;
                    end
                    else
                    begin
                        state_next = tlbd_pkg::FSM_GO;
                    end
                end
            end
            tlbd_pkg::FSM_GO: state_next = tlbd_pkg::FSM_WAIT;
            tlbd_pkg::FSM_WAIT:
            begin
                if (mul_done)
                begin
                    if (op_reg == tlbd_pkg::OP_THR)
                    begin
                        state_next = tlbd_pkg::FSM_SCAN;
                    end
                    else if (last_weight && (total_sum == '0))
                    begin
                        state_next = tlbd_pkg::FSM_OUT;
                    end
                    else
                    begin
                        state_next = tlbd_pkg::FSM_GO;
                    end
                end
            end
            tlbd_pkg::FSM_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = tlbd_pkg::FSM_UPDATE;
                end
            end
            tlbd_pkg::FSM_UPDATE: state_next = tlbd_pkg::FSM_OUT;
            tlbd_pkg::FSM_OUT:
            begin
                if (out_xfer)
                begin
                    state_next = tlbd_pkg::FSM_IDLE;
                end
            end
            default: state_next = tlbd_pkg::FSM_IDLE;
        endcase
    end

    // handshake
    always_comb
    begin
        in_ch.ready   = state_reg == tlbd_pkg::FSM_IDLE;
        out_ch.valid  = state_reg == tlbd_pkg::FSM_OUT;
    end

    // control state, counts and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tlbd_pkg::FSM_IDLE;
            op_reg          <= tlbd_pkg::OP_BSUM_A;
            idx_reg         <= 2'd0;
            k_reg           <= '0;
            cnt_reg[0]      <= '0;
            cnt_reg[1]      <= '0;
            cnt_reg[2]      <= '0;
            cnt_reg[3]      <= '0;
            birth_big_reg   <= tlbd_pkg::RATE_RESET;
            birth_small_reg <= tlbd_pkg::RATE_RESET;
            death_big_reg   <= tlbd_pkg::RATE_RESET;
            death_small_reg <= tlbd_pkg::RATE_RESET;
            recomb_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    tlbd_pkg::REG_BIRTH_BIG_A:   birth_big_reg   <= cfg_data;
                    tlbd_pkg::REG_BIRTH_SMALL_A: birth_small_reg <= cfg_data;
                    tlbd_pkg::REG_DEATH_BIG_A:   death_big_reg   <= cfg_data;
                    tlbd_pkg::REG_DEATH_SMALL_A: death_small_reg <= cfg_data;
                    tlbd_pkg::REG_RECOMB:
                        recomb_reg <= cfg_data[tlbd_pkg::RECOMB_BITS-1:0];
                    default: recomb_reg <= recomb_reg;
                endcase
            end

            case (state_reg)
                tlbd_pkg::FSM_IDLE:
                begin
                    op_reg  <= tlbd_pkg::OP_BSUM_A;
                    idx_reg <= 2'd0;
                    if (in_xfer && (in_ch.opcode == tlbd_pkg::OPC_LOAD))
                    begin
                        cnt_reg[0] <= in_ch.load_big_a_big_b;
                        cnt_reg[1] <= in_ch.load_big_a_small_b;
                        cnt_reg[2] <= in_ch.load_small_a_big_b;
                        cnt_reg[3] <= in_ch.load_small_a_small_b;
                    end
                end
                tlbd_pkg::FSM_WAIT:
                begin
                    if (mul_done)
                    begin
                        op_reg  <= op_next;
                        idx_reg <= idx_next;
                        k_reg   <= '0;
                    end
                end
                tlbd_pkg::FSM_SCAN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (scan_end)
                    begin
                        idx_reg <= k_reg[1:0];
                    end
                end
                tlbd_pkg::FSM_UPDATE:
                begin
                    if (!sat)
                    begin
                        if (ev_reg[2])
                        begin
                            cnt_reg[idx_reg] <= cnt_sel - 1'b1;
                        end
                        else
                        begin
                            cnt_reg[idx_reg] <= cnt_sel + 1'b1;
                        end
                    end
                end
                default: k_reg <= k_reg;
            endcase
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tlbd_pkg::FSM_IDLE:
            begin
                if (in_xfer)
                begin
                    draw_reg  <= in_ch.random_draw;
                    total_reg <= '0;
                    ev_reg    <= tlbd_pkg::EV_NONE;
                    if ((in_ch.opcode == tlbd_pkg::OPC_STEP) && (s_sum == '0))
                    begin
                        status_reg <= tlbd_pkg::STS_EMPTY;
                    end
                    else
                    begin
                        status_reg <= tlbd_pkg::STS_OK;
                    end
                end
            end
            tlbd_pkg::FSM_WAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        tlbd_pkg::OP_BSUM_A, tlbd_pkg::OP_BSUM_B:
                            bsum_reg <= mul_res[tlbd_pkg::BSUM_BITS-1:0];
                        tlbd_pkg::OP_P:   p_reg   <= mul_res[tlbd_pkg::PQ_BITS-1:0];
                        tlbd_pkg::OP_Q:   q_reg   <= mul_res[tlbd_pkg::PQ_BITS-1:0];
                        tlbd_pkg::OP_RDL: rdl_reg <= mul_res[tlbd_pkg::RDL_BITS-1:0];
                        tlbd_pkg::OP_S2:  s2_reg  <= mul_res[tlbd_pkg::S2_BITS-1:0];
                        tlbd_pkg::OP_BASE: share_reg <= share_calc;
                        tlbd_pkg::OP_BIRTH:
                        begin
                            wt_reg[{1'b0, idx_reg}] <= wt_new;
                            total_reg <= total_sum;
                        end
                        tlbd_pkg::OP_ND: nd_reg <= mul_res[tlbd_pkg::ND_BITS-1:0];
                        tlbd_pkg::OP_DEATH:
                        begin
                            wt_reg[{1'b1, idx_reg}] <= wt_new;
                            total_reg <= total_sum;
                            if (last_weight && (total_sum == '0))
                            begin
                                status_reg <= tlbd_pkg::STS_RATE_ZERO;
                            end
                        end
                        tlbd_pkg::OP_THR:
                        begin
                            thr_reg <= mul_res;
                            cum_reg <= '0;
                        end
                        default: cum_reg <= cum_reg;
                    endcase
                end
            end
            tlbd_pkg::FSM_SCAN:
            begin
                cum_reg <= cum_sum;
                if (scan_end)
                begin
                    ev_reg <= tlbd_pkg::EV_BITS'(k_reg);
                end
            end
            tlbd_pkg::FSM_UPDATE:
            begin
                if (sat)
                begin
                    status_reg <= tlbd_pkg::STS_SATURATED;
                end
            end
            default: cum_reg <= cum_reg;
        endcase
    end

    tlbd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .a     (mul_a),
        .b     (mul_b),
        .init  (mul_init),
        .done  (mul_done),
        .res   (mul_res)
    );

    // result payload straight from the held state
    assign out_ch.count_big_a_big_b     = cnt_reg[0];
    assign out_ch.count_big_a_small_b   = cnt_reg[1];
    assign out_ch.count_small_a_big_b   = cnt_reg[2];
    assign out_ch.count_small_a_small_b = cnt_reg[3];
    assign out_ch.event_res             = ev_reg;
    assign out_ch.status                = status_reg;

    `TLBD_ASSERT(a_one_side, !(in_ch.ready && out_ch.valid), "input taken while result pending")
    `TLBD_ASSERT_IMP(a_sat_event, out_ch.valid && (status_reg == tlbd_pkg::STS_SATURATED), ev_reg != tlbd_pkg::EV_NONE, "saturated result without event")
    `TLBD_ASSERT_IMP(a_done_in_wait, mul_done, state_reg == tlbd_pkg::FSM_WAIT, "product finished outside wait")

endmodule
